>>> sv/llcr_pkg.sv
// Shared types, constants and codes of the least-loaded core rebalancer.
package llcr_pkg;

  localparam int N_BUCKETS_DEF = 128;
  localparam int CORES_DEF     = 4;
  localparam int SERVERS_DEF   = 4;

  localparam int OP_W     = 2;
  localparam int SERVER_W = 3;
  localparam int BUCKET_W = 7;
  localparam int CORE_W   = 2;
  localparam int LOAD_W   = 16;
  localparam int ALPHA_W  = 9;
  localparam int TSRV_W   = 2;
  localparam int MAP_W    = 2;
  localparam int SMOOTH_W = 32;
  localparam int LDRAM_W  = SMOOTH_W + LOAD_W;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;
  localparam logic [ALPHA_W-1:0] ALPHA_FULL  = 9'd256;

  localparam logic signed [SMOOTH_W-1:0] LOAD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SMOOTH_W-1:0] LOAD_MIN = 32'sh8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_MAP   = 2'd0,
    OP_LOAD_REPORT = 2'd1,
    OP_REHASH      = 2'd2,
    OP_LOOKUP      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_LR_MUL,
    ST_LR_WR,
    ST_REHASH
  } st_e;

  typedef struct packed {
    op_e                 op;
    logic                known;
    logic [SERVER_W-1:0] server;
    logic [BUCKET_W-1:0] bucket;
    logic [CORE_W-1:0]   core;
    logic [LOAD_W-1:0]   load_value;
    logic [TSRV_W-1:0]   def_tsrv;
  } cmd_t;

  typedef struct packed {
    logic              status;
    logic [TSRV_W-1:0] table_server;
    logic [MAP_W-1:0]  mapped_core;
  } res_t;

endpackage

>>> sv/least_loaded_core_rebalancer.sv
// Top level of the least-loaded core rebalancer: front end, back end and result queue.
//
// Words enter through a two-entry command queue and results leave through a two-entry
// result queue, so either side may stall on its own. The back end carries out one command
// at a time: a map write, or a load report with an unknown server, is answered when it
// is taken; a lookup reads the server table and core map and then answers; a load report
// reads the load memory, multiplies, then blends and writes back; a rehash walks the
// table, reading the core map through its one read port once per server and bucket.
// After reset all SERVERS * CORES entries of the load memory are cleared in turn, with
// full held high; configuration writes are taken at all times and ready is always high.
module least_loaded_core_rebalancer #(
  parameter int N_BUCKETS = llcr_pkg::N_BUCKETS_DEF,
  parameter int CORES     = llcr_pkg::CORES_DEF,
  parameter int SERVERS   = llcr_pkg::SERVERS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [llcr_pkg::OP_W-1:0]     operation_i,
  input  logic [llcr_pkg::SERVER_W-1:0] server_i,
  input  logic [llcr_pkg::BUCKET_W-1:0] bucket_i,
  input  logic [llcr_pkg::CORE_W-1:0]   core_i,
  input  logic [llcr_pkg::LOAD_W-1:0]   load_value_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          status_o,
  output logic [llcr_pkg::TSRV_W-1:0]   table_server_o,
  output logic [llcr_pkg::MAP_W-1:0]    mapped_core_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [llcr_pkg::ALPHA_W-1:0]  cfg_data_i
);

  llcr_pkg::cmd_t cmd;
  llcr_pkg::res_t res_in, res_out;
  logic           cmd_valid, cmd_pop, res_full, res_push, clearing;
  logic [$bits(llcr_pkg::res_t)-1:0] res_word;

  assign cfg_ready_o = 1'b1;

  llcr_front #(
    .N_BUCKETS (N_BUCKETS),
    .CORES     (CORES),
    .SERVERS   (SERVERS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .operation_i  (operation_i),
    .server_i     (server_i),
    .bucket_i     (bucket_i),
    .core_i       (core_i),
    .load_value_i (load_value_i),
    .hold_i       (clearing),
    .full_o       (full),
    .cmd_o        (cmd),
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop)
  );

  llcr_back #(
    .N_BUCKETS (N_BUCKETS),
    .CORES     (CORES),
    .SERVERS   (SERVERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .clearing_o  (clearing)
  );

  llcr_fifo #(
    .WIDTH ($bits(llcr_pkg::res_t)),
    .DEPTH (llcr_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_word)
  );

  assign res_out        = llcr_pkg::res_t'(res_word);
  assign status_o       = res_out.status;
  assign table_server_o = res_out.table_server;
  assign mapped_core_o  = res_out.mapped_core;

endmodule

>>> sv/llcr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module llcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> sv/llcr_fifo.sv
// Small first-in first-out queue of words, used for commands and results.
module llcr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> sv/llcr_front.sv
// Front end: accepts input words, reduces their indexes and queues them as commands.
module llcr_front #(
  parameter int N_BUCKETS = llcr_pkg::N_BUCKETS_DEF,
  parameter int CORES     = llcr_pkg::CORES_DEF,
  parameter int SERVERS   = llcr_pkg::SERVERS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [llcr_pkg::OP_W-1:0]     operation_i,
  input  logic [llcr_pkg::SERVER_W-1:0] server_i,
  input  logic [llcr_pkg::BUCKET_W-1:0] bucket_i,
  input  logic [llcr_pkg::CORE_W-1:0]   core_i,
  input  logic [llcr_pkg::LOAD_W-1:0]   load_value_i,
  input  logic                          hold_i,
  output logic                          full_o,
  output llcr_pkg::cmd_t                cmd_o,
  output logic                          cmd_valid_o,
  input  logic                          cmd_pop_i
);

  localparam int BUCKETS = 2 ** llcr_pkg::BUCKET_W;
  localparam int CORE_VALS = 2 ** llcr_pkg::CORE_W;

  llcr_pkg::cmd_t cmd_in;
  logic           q_full, q_empty;
  logic [$bits(llcr_pkg::cmd_t)-1:0] q_out;

  always_comb begin
    cmd_in            = '0;
    cmd_in.op         = llcr_pkg::op_e'(operation_i);
    cmd_in.known      = (32'(server_i) < SERVERS);
    cmd_in.server     = server_i;
    cmd_in.load_value = load_value_i;
    for (int i = 0; i < BUCKETS; i++) begin
      if (bucket_i == llcr_pkg::BUCKET_W'(i)) begin
        cmd_in.bucket   = llcr_pkg::BUCKET_W'(i % N_BUCKETS);
        cmd_in.def_tsrv = llcr_pkg::TSRV_W'((i % N_BUCKETS) % SERVERS);
      end
    end
    for (int j = 0; j < CORE_VALS; j++) begin
      if (core_i == llcr_pkg::CORE_W'(j)) begin
        cmd_in.core = llcr_pkg::CORE_W'(j % CORES);
      end
    end
  end

  llcr_fifo #(
    .WIDTH ($bits(llcr_pkg::cmd_t)),
    .DEPTH (llcr_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && !full_o),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (cmd_pop_i),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  assign full_o      = q_full || hold_i;
  assign cmd_valid_o = !q_empty;
  assign cmd_o       = llcr_pkg::cmd_t'(q_out);

endmodule

>>> sv/llcr_back.sv
// Back end: sequencer that carries out commands on the map, load and table memories.
module llcr_back #(
  parameter int N_BUCKETS = llcr_pkg::N_BUCKETS_DEF,
  parameter int CORES     = llcr_pkg::CORES_DEF,
  parameter int SERVERS   = llcr_pkg::SERVERS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [llcr_pkg::ALPHA_W-1:0] cfg_data_i,
  input  llcr_pkg::cmd_t               cmd_i,
  input  logic                         cmd_valid_i,
  output logic                         cmd_pop_o,
  input  logic                         res_full_i,
  output logic                         res_push_o,
  output llcr_pkg::res_t               res_o,
  output logic                         clearing_o
);

  localparam int MAP_DEPTH = SERVERS * N_BUCKETS;
  localparam int LD_DEPTH  = SERVERS * CORES;
  localparam int MW  = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int LAW = (LD_DEPTH > 1) ? $clog2(LD_DEPTH) : 1;
  localparam int BW  = $clog2(N_BUCKETS);
  localparam int SW  = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam logic signed [43:0] SUM_MAX = 44'sd2147483647;
  localparam logic signed [43:0] SUM_MIN = -44'sd2147483648;

  llcr_pkg::st_e state_q, state_d;
  llcr_pkg::cmd_t cmd_q, cmd_d;
  logic [llcr_pkg::ALPHA_W-1:0] alpha_q, alpha_sat, alpha_inv;
  logic [LAW-1:0] clr_cnt_q, clr_cnt_d;
  logic [SW-1:0]  iss_s_q, iss_s_d, s1_q, s1_d, s2_q, s2_d, best_idx_q, best_idx_d;
  logic [BW-1:0]  iss_b_q, iss_b_d, b1_q, b1_d, b2_q, b2_d;
  logic           iss_done_q, iss_done_d, v1_q, v1_d, v2_q, v2_d;
  logic           rehashed_q, rehashed_d;
  logic signed [llcr_pkg::SMOOTH_W-1:0] best_load_q, best_load_d;
  logic signed [26:0] mul_ad_q, mul_ad_d;
  logic signed [41:0] mul_s_q, mul_s_d;

  logic signed [16:0] load_diff;
  logic signed [43:0] sum_w, quot_w;
  logic signed [llcr_pkg::SMOOTH_W-1:0] sat_w, cand_load, cur_best;
  logic [SW-1:0]  cur_idx;
  logic           take;

  logic                             map_we, map_re, tbl_we, tbl_re, ld_we, ld_re;
  logic [MW-1:0]                    map_waddr, map_raddr;
  logic [llcr_pkg::MAP_W-1:0]       map_wdata, map_rdata;
  logic [BW-1:0]                    tbl_waddr, tbl_raddr;
  logic [llcr_pkg::TSRV_W-1:0]      tbl_wdata, tbl_rdata;
  logic [LAW-1:0]                   ld_waddr, ld_raddr;
  logic [llcr_pkg::LDRAM_W-1:0]     ld_wdata, ld_rdata;

  assign alpha_sat  = (alpha_q > llcr_pkg::ALPHA_FULL) ? llcr_pkg::ALPHA_FULL : alpha_q;
  assign alpha_inv  = llcr_pkg::ALPHA_FULL - alpha_sat;
  assign load_diff  = $signed({1'b0, cmd_q.load_value}) - $signed({1'b0, ld_rdata[15:0]});
  assign sum_w      = 44'(mul_ad_q) + 44'(mul_s_q) + 44'sd128;
  assign quot_w     = sum_w >>> 8;
  assign sat_w      = (quot_w > SUM_MAX) ? llcr_pkg::LOAD_MAX :
                      (quot_w < SUM_MIN) ? llcr_pkg::LOAD_MIN : quot_w[31:0];
  assign cand_load  = $signed(ld_rdata[llcr_pkg::LDRAM_W-1:llcr_pkg::LOAD_W]);
  assign cur_best   = (s2_q == '0) ? llcr_pkg::LOAD_MAX : best_load_q;
  assign cur_idx    = (s2_q == '0) ? '0 : best_idx_q;
  assign take       = (cand_load < cur_best);
  assign clearing_o = (state_q == llcr_pkg::ST_CLEAR);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    clr_cnt_d   = clr_cnt_q;
    iss_s_d     = iss_s_q;
    iss_b_d     = iss_b_q;
    iss_done_d  = iss_done_q;
    v1_d        = 1'b0;
    s1_d        = iss_s_q;
    b1_d        = iss_b_q;
    v2_d        = 1'b0;
    s2_d        = s1_q;
    b2_d        = b1_q;
    best_load_d = best_load_q;
    best_idx_d  = best_idx_q;
    rehashed_d  = rehashed_q;
    mul_ad_d    = mul_ad_q;
    mul_s_d     = mul_s_q;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_o       = '0;
    map_we      = 1'b0;
    map_waddr   = MW'(cmd_i.server) * MW'(N_BUCKETS) + MW'(cmd_i.bucket);
    map_wdata   = cmd_i.core;
    map_re      = 1'b0;
    map_raddr   = MW'(cmd_i.server) * MW'(N_BUCKETS) + MW'(cmd_i.bucket);
    tbl_we      = 1'b0;
    tbl_waddr   = b2_q;
    tbl_wdata   = llcr_pkg::TSRV_W'(take ? s2_q : cur_idx);
    tbl_re      = 1'b0;
    tbl_raddr   = BW'(cmd_i.bucket);
    ld_we       = 1'b0;
    ld_waddr    = LAW'(cmd_q.server) * LAW'(CORES) + LAW'(cmd_q.core);
    ld_wdata    = {sat_w, cmd_q.load_value};
    ld_re       = 1'b0;
    ld_raddr    = LAW'(cmd_i.server) * LAW'(CORES) + LAW'(cmd_i.core);
    case (state_q)
      llcr_pkg::ST_CLEAR: begin
        ld_we    = 1'b1;
        ld_waddr = clr_cnt_q;
        ld_wdata = '0;
        if (clr_cnt_q == LAW'(LD_DEPTH - 1)) begin
          state_d = llcr_pkg::ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      llcr_pkg::ST_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.op)
            llcr_pkg::OP_WRITE_MAP: begin
              map_we       = cmd_i.known;
              res_push_o   = 1'b1;
              res_o.status = !cmd_i.known;
            end
            llcr_pkg::OP_LOAD_REPORT: begin
              if (cmd_i.known) begin
                ld_re   = 1'b1;
                state_d = llcr_pkg::ST_LR_MUL;
              end else begin
                res_push_o   = 1'b1;
                res_o.status = 1'b1;
              end
            end
            llcr_pkg::OP_REHASH: begin
              iss_s_d    = '0;
              iss_b_d    = '0;
              iss_done_d = 1'b0;
              state_d    = llcr_pkg::ST_REHASH;
            end
            llcr_pkg::OP_LOOKUP: begin
              map_re  = cmd_i.known;
              tbl_re  = 1'b1;
              state_d = llcr_pkg::ST_LOOKUP;
            end
            default: begin
              state_d = llcr_pkg::ST_IDLE;
            end
          endcase
        end
      end
      llcr_pkg::ST_LOOKUP: begin
        res_push_o         = 1'b1;
        res_o.status       = !cmd_q.known;
        res_o.table_server = rehashed_q ? tbl_rdata : cmd_q.def_tsrv;
        res_o.mapped_core  = cmd_q.known ? map_rdata : '0;
        state_d            = llcr_pkg::ST_IDLE;
      end
      llcr_pkg::ST_LR_MUL: begin
        mul_ad_d = 27'($signed({1'b0, alpha_sat}) * load_diff);
        mul_s_d  = 42'($signed({1'b0, alpha_inv}) *
                       $signed(ld_rdata[llcr_pkg::LDRAM_W-1:llcr_pkg::LOAD_W]));
        state_d  = llcr_pkg::ST_LR_WR;
      end
      llcr_pkg::ST_LR_WR: begin
        ld_we      = 1'b1;
        res_push_o = 1'b1;
        state_d    = llcr_pkg::ST_IDLE;
      end
      llcr_pkg::ST_REHASH: begin
        if (!iss_done_q) begin
          map_re    = 1'b1;
          map_raddr = MW'(iss_s_q) * MW'(N_BUCKETS) + MW'(iss_b_q);
          v1_d      = 1'b1;
          if (iss_s_q == SW'(SERVERS - 1)) begin
            iss_s_d = '0;
            if (iss_b_q == BW'(N_BUCKETS - 1)) begin
              iss_done_d = 1'b1;
            end else begin
              iss_b_d = iss_b_q + 1'b1;
            end
          end else begin
            iss_s_d = iss_s_q + 1'b1;
          end
        end
        if (v1_q) begin
          ld_re    = 1'b1;
          ld_raddr = LAW'(s1_q) * LAW'(CORES) + LAW'(map_rdata);
          v2_d     = 1'b1;
        end
        if (v2_q) begin
          best_load_d = take ? cand_load : cur_best;
          best_idx_d  = take ? s2_q : cur_idx;
          tbl_we      = (s2_q == SW'(SERVERS - 1));
        end
        if (iss_done_q && !v1_q && !v2_q) begin
          res_push_o = 1'b1;
          rehashed_d = 1'b1;
          state_d    = llcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = llcr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= llcr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= llcr_pkg::ALPHA_RESET;
      clr_cnt_q  <= '0;
      iss_s_q    <= '0;
      iss_b_q    <= '0;
      iss_done_q <= 1'b1;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      rehashed_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        alpha_q <= cfg_data_i;
      end
      clr_cnt_q  <= clr_cnt_d;
      iss_s_q    <= iss_s_d;
      iss_b_q    <= iss_b_d;
      iss_done_q <= iss_done_d;
      v1_q       <= v1_d;
      v2_q       <= v2_d;
      rehashed_q <= rehashed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    s1_q        <= s1_d;
    b1_q        <= b1_d;
    s2_q        <= s2_d;
    b2_q        <= b2_d;
    best_load_q <= best_load_d;
    best_idx_q  <= best_idx_d;
    mul_ad_q    <= mul_ad_d;
    mul_s_q     <= mul_s_d;
  end

  llcr_ram #(
    .WIDTH (llcr_pkg::MAP_W),
    .DEPTH (MAP_DEPTH)
  ) u_core_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  llcr_ram #(
    .WIDTH (llcr_pkg::TSRV_W),
    .DEPTH (N_BUCKETS)
  ) u_server_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  llcr_ram #(
    .WIDTH (llcr_pkg::LDRAM_W),
    .DEPTH (LD_DEPTH)
  ) u_load (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (ld_waddr),
    .wdata_i (ld_wdata),
    .re_i    (ld_re),
    .raddr_i (ld_raddr),
    .rdata_o (ld_rdata)
  );

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("Result word pushed into a full result queue.");

  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q))
    else $error("Load stage of the rehash walk ran without a map read before it.");

  a_rehashed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rehashed_q |=> rehashed_q)
    else $error("Rehash flag cleared after the table was rebuilt.");

  a_lookup_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == llcr_pkg::ST_LOOKUP) |-> $past(cmd_pop_o))
    else $error("Lookup result stage entered without a command taken.");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench of the least-loaded core rebalancer: directed table and random words, checked by table or model.
module tb;
  import llcr_pkg::*;

  localparam int NTAB       = N_BUCKETS_DEF;
  localparam int NCORE      = CORES_DEF;
  localparam int NSRV       = SERVERS_DEF;
  localparam int RAND_WORDS = 420;
  localparam int N_PHASES   = 6;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_AT    = 700;
  localparam int HOLD_LEN   = 400;
  localparam int SETTLE     = 8;
  localparam int TAIL       = 24;
  localparam int MAX_PRINTS = 100;

  typedef struct {
    op_e                 op;
    logic [SERVER_W-1:0] server;
    logic [BUCKET_W-1:0] bucket;
    logic [CORE_W-1:0]   core;
    logic [LOAD_W-1:0]   load;
    bit                  typed;
    res_t                want;
  } word_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                push      = 1'b0;
  logic                full;
  logic [OP_W-1:0]     op_d      = '0;
  logic [SERVER_W-1:0] server_d  = '0;
  logic [BUCKET_W-1:0] bucket_d  = '0;
  logic [CORE_W-1:0]   core_d    = '0;
  logic [LOAD_W-1:0]   load_d    = '0;
  logic                empty;
  logic                pop       = 1'b0;
  logic                status_q;
  logic [TSRV_W-1:0]   tsrv_q;
  logic [MAP_W-1:0]    mcore_q;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ALPHA_W-1:0]  cfg_data  = '0;

  logic [ALPHA_W-1:0] alpha_m;
  logic [MAP_W-1:0]   core_map_m [NSRV*NTAB];
  logic [TSRV_W-1:0]  srv_tab_m  [NTAB];
  int                 smooth_m   [NSRV*NCORE];
  logic [LOAD_W-1:0]  raw_m      [NSRV*NCORE];

  res_t        exp_res_q [$];
  word_t       dir_q [$];
  int          err_cnt    = 0;
  int          words_out  = 0;
  int          burst_left = 0;
  int          hold_left  = 0;
  bit          hold_done  = 1'b0;
  int unsigned rx_cycle   = 0;

  always #6 clk = ~clk;

  least_loaded_core_rebalancer u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .operation_i    (op_d),
    .server_i       (server_d),
    .bucket_i       (bucket_d),
    .core_i         (core_d),
    .load_value_i   (load_d),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_q),
    .table_server_o (tsrv_q),
    .mapped_core_o  (mcore_q),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  task automatic flag_mismatch(string what, int got, int want);
    if (err_cnt < MAX_PRINTS) begin
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    end
    err_cnt++;
  endtask

  function automatic int blend_load(int old_s, logic [LOAD_W-1:0] old_raw,
                                    logic [LOAD_W-1:0] fresh, logic [ALPHA_W-1:0] alpha);
    longint a, f, r, sum, q;
    if (alpha > ALPHA_FULL) a = 256;
    else a = alpha;
    f = fresh;
    r = old_raw;
    sum = a * (f - r) + (256 - a) * longint'(old_s) + 128;
    q = sum >>> 8;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return int'(q);
  endfunction

  task automatic rehash_table();
    int best_l, best, c, l;
    for (int b = 0; b < NTAB; b++) begin
      best_l = LOAD_MAX;
      best = 0;
      for (int s = 0; s < NSRV; s++) begin
        c = core_map_m[s*NTAB + b];
        l = smooth_m[s*NCORE + c];
        if (l < best_l) begin
          best_l = l;
          best = s;
        end
      end
      srv_tab_m[b] = TSRV_W'(best);
    end
  endtask

  task automatic predict_rebalance(input word_t w, output res_t r);
    int k;
    bit known;
    r = '0;
    known = (int'(w.server) < NSRV);
    case (w.op)
      OP_WRITE_MAP: begin
        if (known) core_map_m[int'(w.server)*NTAB + int'(w.bucket)] = w.core;
        else r.status = 1'b1;
      end
      OP_LOAD_REPORT: begin
        if (known) begin
          k = int'(w.server)*NCORE + int'(w.core);
          smooth_m[k] = blend_load(smooth_m[k], raw_m[k], w.load, alpha_m);
          raw_m[k] = w.load;
        end else begin
          r.status = 1'b1;
        end
      end
      OP_REHASH: rehash_table();
      default: begin
        r.table_server = srv_tab_m[w.bucket];
        if (known) r.mapped_core = core_map_m[int'(w.server)*NTAB + int'(w.bucket)];
        else r.status = 1'b1;
      end
    endcase
  endtask

  function automatic word_t mk_word(op_e op, int srv, int bkt, int core, int load);
    word_t w;
    w.op = op;
    w.server = SERVER_W'(srv);
    w.bucket = BUCKET_W'(bkt);
    w.core = CORE_W'(core);
    w.load = LOAD_W'(load);
    w.typed = 1'b0;
    w.want = '0;
    return w;
  endfunction

  task automatic add_row(op_e op, int srv, int bkt, int core, int load,
                         bit typed, int st, int ts, int mc);
    word_t w;
    w = mk_word(op, srv, bkt, core, load);
    w.typed = typed;
    w.want.status = st[0];
    w.want.table_server = TSRV_W'(ts);
    w.want.mapped_core = MAP_W'(mc);
    dir_q.push_back(w);
  endtask

  function automatic word_t rand_word();
    word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) w.op = OP_WRITE_MAP;
    else if (pick < 63) w.op = OP_LOAD_REPORT;
    else if (pick < 66) w.op = OP_REHASH;
    else w.op = OP_LOOKUP;
    if ($urandom_range(0, 9) == 0) w.server = SERVER_W'($urandom_range(NSRV, 7));
    else w.server = SERVER_W'($urandom_range(0, NSRV - 1));
    w.bucket = BUCKET_W'($urandom);
    w.core = CORE_W'($urandom);
    case ($urandom_range(0, 5))
      0: w.load = '0;
      1: w.load = '1;
      2: w.load = LOAD_W'($urandom_range(0, 15));
      default: w.load = LOAD_W'($urandom);
    endcase
    w.typed = 1'b0;
    w.want = '0;
    return w;
  endfunction

  task automatic send_word(input word_t w);
    res_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push     <= 1'b1;
    op_d     <= w.op;
    server_d <= w.server;
    bucket_d <= w.bucket;
    core_d   <= w.core;
    load_d   <= w.load;
    do @(posedge clk); while (full);
    predict_rebalance(w, r);
    exp_res_q.push_back(w.typed ? w.want : r);
  endtask

  task automatic drain_results(int extra);
    push <= 1'b0;
    while (exp_res_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_alpha(logic [ALPHA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    alpha_m = v;
  endtask

  always @(posedge clk) begin : rx
    res_t want;
    if (pop && !empty) begin
      words_out++;
      if (exp_res_q.size() == 0) begin
        flag_mismatch("word with nothing expected", status_q, 0);
      end else begin
        want = exp_res_q.pop_front();
        if (status_q !== want.status) flag_mismatch("status", status_q, want.status);
        if (tsrv_q !== want.table_server) begin
          flag_mismatch("table_server", tsrv_q, want.table_server);
        end
        if (mcore_q !== want.mapped_core) flag_mismatch("mapped_core", mcore_q, want.mapped_core);
      end
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (!hold_done && words_out >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      pop <= 1'b0;
    end else begin
      case (rx_cycle[8:6])
        3'd0, 3'd1: pop <= 1'b1;
        3'd2, 3'd3: pop <= 1'($urandom_range(0, 1));
        3'd4: pop <= (rx_cycle[1:0] == 2'd0);
        3'd5: pop <= ($urandom_range(0, 9) != 0);
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle = 0;
      else idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stim
    logic [ALPHA_W-1:0] alphas [N_PHASES];
    alphas = '{9'd0, 9'd256, 9'd511, 9'd255, 9'd1, 9'd0};
    alphas[N_PHASES-1] = ALPHA_W'($urandom_range(0, 511));

    alpha_m = ALPHA_RESET;
    for (int i = 0; i < NSRV*NTAB; i++) core_map_m[i] = '0;
    for (int i = 0; i < NTAB; i++) srv_tab_m[i] = TSRV_W'(i % NSRV);
    for (int i = 0; i < NSRV*NCORE; i++) begin
      smooth_m[i] = 0;
      raw_m[i] = '0;
    end

    // The fill below maps bucket b of server s to core (s + b) mod 4.
    add_row(OP_LOOKUP,      4,   0, 0,     0, 1, 1, 0, 0);
    add_row(OP_LOOKUP,      7, 127, 3, 65535, 1, 1, 3, 0);
    add_row(OP_LOOKUP,      0, 127, 0,     0, 1, 0, 3, 3);
    add_row(OP_LOOKUP,      3,   1, 2,     0, 1, 0, 1, 0);
    add_row(OP_WRITE_MAP,   5,   9, 3,     0, 1, 1, 0, 0);
    add_row(OP_WRITE_MAP,   0, 127, 0,     0, 1, 0, 0, 0);
    add_row(OP_LOOKUP,      0, 127, 0,     0, 1, 0, 3, 0);
    add_row(OP_WRITE_MAP,   3,   0, 3, 65535, 1, 0, 0, 0);
    add_row(OP_LOAD_REPORT, 6,   0, 2, 65535, 1, 1, 0, 0);
    add_row(OP_LOAD_REPORT, 0,   0, 0, 65535, 1, 0, 0, 0);
    add_row(OP_LOAD_REPORT, 0,   0, 0,     0, 1, 0, 0, 0);
    add_row(OP_LOAD_REPORT, 1,   0, 3, 65535, 1, 0, 0, 0);
    add_row(OP_LOAD_REPORT, 2,   0, 1,     1, 1, 0, 0, 0);
    add_row(OP_LOAD_REPORT, 3,   0, 2,     0, 1, 0, 0, 0);
    add_row(OP_REHASH,      0,   0, 0,     0, 1, 0, 0, 0);
    add_row(OP_LOOKUP,      0,   0, 0,     0, 0, 0, 0, 0);
    add_row(OP_LOOKUP,      1,   1, 0,     0, 0, 0, 0, 0);
    add_row(OP_LOOKUP,      2,  64, 0,     0, 0, 0, 0, 0);
    add_row(OP_LOOKUP,      3, 127, 0,     0, 0, 0, 0, 0);
    add_row(OP_LOOKUP,      4,   5, 0,     0, 0, 0, 0, 0);
    add_row(OP_LOAD_REPORT, 0,   0, 0, 65535, 0, 0, 0, 0);
    add_row(OP_REHASH,      7, 127, 3, 65535, 0, 0, 0, 0);
    add_row(OP_LOOKUP,      1,   2, 0,     0, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Every map entry is written before any rehash, as the walk reads them all.
    for (int s = 0; s < NSRV; s++) begin
      for (int b = 0; b < NTAB; b++) begin
        send_word(mk_word(OP_WRITE_MAP, s, b, s + b, $urandom));
      end
    end

    while (dir_q.size() != 0) send_word(dir_q.pop_front());

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results(SETTLE);
      write_alpha(alphas[ph]);
      repeat (RAND_WORDS / N_PHASES) send_word(rand_word());
    end

    drain_results(TAIL);
    if (err_cnt == 0 && exp_res_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/llcr_pkg.sv
sv/llcr_ram.sv
sv/llcr_fifo.sv
sv/llcr_front.sv
sv/llcr_back.sv
sv/least_loaded_core_rebalancer.sv
dv/tb.sv
